// ===== rtl/sfcf_pkg.sv =====
// Shared types, constants and the coefficient table of the stereo fast-convolution FIR.
// Depends on nothing; every other file of the block uses it by scoped names.
package sfcf_pkg;

  // Width of every sample field on the channels.
  localparam int FIELD_BITS = 16;

  // Width of the wrapping product accumulator.
  localparam int ACC_BITS = 40;

  // Number of tabulated coefficients; taps beyond the table are zero.
  localparam int TABLE_LEN = 64;

  // Symmetric low-pass filter, Q1.15, rounded to nearest.
  localparam int COEF_Q15 [TABLE_LEN] = '{
        26,   24,   17,    4,  -14,  -37,  -61,  -80,
       -83,  -65,  -20,   50,  135,  217,  274,  279,
       214,   73, -135, -378, -607, -764, -785, -620,
      -238,  358, 1130, 2008, 2896, 3687, 4281, 4599,
      4599, 4281, 3687, 2896, 2008, 1130,  358, -238,
      -620, -785, -764, -607, -378, -135,   73,  214,
       279,  274,  217,  135,   50,  -20,  -65,  -83,
       -80,  -61,  -37,  -14,    4,   17,   24,   26
  };

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN
  } state_t;

  // Per-cycle commands from the sequencer to both lanes.
  typedef struct packed {
    logic load;    // capture a new sample, clear the accumulator
    logic issue;   // fetch the next operand
    logic first;   // operand is the new sample, not the history
    logic mul;     // form the product
    logic acc;     // add the product into the accumulator
    logic commit;  // push the sample into the history
  } lane_ctl_t;

  // Coefficient of tap k scaled to cb bits: shift left for wide coefficients,
  // round to nearest (ties up) for narrow ones.
  function automatic int coef_value(input int k, input int cb);
    int q;
    int s;
    if (k < 0 || k >= TABLE_LEN) begin
      return 0;
    end
    q = COEF_Q15[k];
    if (cb >= 16) begin
      return q <<< (cb - 16);
    end
    s = 16 - cb;
    return (q + (1 <<< (s - 1))) >>> s;
  endfunction

endpackage

// ===== rtl/sfcf_in_if.sv =====
// Input channel of the stereo fast-convolution FIR: one stereo sample pair per transaction.
// Depends on sfcf_pkg for the field width.
interface sfcf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sfcf_pkg::FIELD_BITS-1:0] chan_a_in;
  logic signed [sfcf_pkg::FIELD_BITS-1:0] chan_b_in;

  modport source (output valid, output chan_a_in, output chan_b_in, input ready);
  modport sink   (input valid, input chan_a_in, input chan_b_in, output ready);
endinterface

// ===== rtl/sfcf_out_if.sv =====
// Output channel of the stereo fast-convolution FIR: one filtered pair per transaction.
// Depends on sfcf_pkg for the field width.
interface sfcf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sfcf_pkg::FIELD_BITS-1:0] chan_a_out;
  logic signed [sfcf_pkg::FIELD_BITS-1:0] chan_b_out;

  modport source (output valid, output chan_a_out, output chan_b_out, input ready);
  modport sink   (input valid, input chan_a_out, input chan_b_out, output ready);
endinterface

// ===== rtl/sfcf_lane.sv =====
// One filter lane: rotating history line, multiplier and 40-bit accumulator,
// followed by truncation toward zero and saturation. Depends on sfcf_pkg.
module sfcf_lane #(
  parameter int TAP_COUNT   = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sfcf_pkg::lane_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [COEFF_BITS-1:0]  coef,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int HIST_LEN  = TAP_COUNT - 1;
  localparam int PROD_BITS = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W     = sfcf_pkg::ACC_BITS;
  localparam int SHIFT     = COEFF_BITS - 1;
  localparam logic signed [ACC_W-1:0] BIAS =
    ACC_W'((longint'(1) <<< SHIFT) - longint'(1));
  localparam logic signed [ACC_W-1:0] LIM_HI =
    ACC_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
  localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - ACC_W'(1);

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] hist [HIST_LEN];
  logic signed [SAMPLE_BITS-1:0] opnd;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       quot;

  // History line: rotate one place per history operand fetch, shift in on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist[i] <= '0;
      end
    end else if (ctl.commit) begin
      hist[0] <= x;
      for (int i = 1; i < HIST_LEN; i++) begin
        hist[i] <= hist[i-1];
      end
    end else if (ctl.issue && !ctl.first) begin
      for (int i = 0; i < HIST_LEN - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[HIST_LEN-1] <= hist[0];
    end
  end

  // Datapath: operand fetch, product, accumulate.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= sample;
    end
    if (ctl.issue) begin
      opnd <= ctl.first ? x : hist[0];
    end
    if (ctl.mul) begin
      prod <= coef * opnd;
    end
    if (ctl.load) begin
      acc <= '0;
    end else if (ctl.acc) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Truncate toward zero, then saturate.
  always_comb begin
    quot = (acc[ACC_W-1] ? acc + BIAS : acc) >>> SHIFT;
    priority if (quot > LIM_HI) begin
      result = LIM_HI[SAMPLE_BITS-1:0];
    end else if (quot < LIM_LO) begin
      result = LIM_LO[SAMPLE_BITS-1:0];
    end else begin
      result = quot[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/sfcf_merge.sv =====
// Merging stage: joins the two lane results into one output transaction and holds it
// in the output register until taken. Depends on sfcf_pkg and sfcf_out_if.
module sfcf_merge #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] res_a,
  input  logic signed [SAMPLE_BITS-1:0] res_b,
  output logic                          can_load,
  sfcf_out_if.source                    result_ch
);

  localparam int FB = sfcf_pkg::FIELD_BITS;
  localparam int MW = (SAMPLE_BITS > FB) ? SAMPLE_BITS : FB;

  logic [MW-1:0] wide_a;
  logic [MW-1:0] wide_b;
  logic          valid;

  // Zero above the sample width, drop bits beyond the field.
  assign wide_a   = MW'($unsigned(res_a));
  assign wide_b   = MW'($unsigned(res_b));
  assign can_load = !valid || result_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_ch.chan_a_out <= $signed(wide_a[FB-1:0]);
      result_ch.chan_b_out <= $signed(wide_b[FB-1:0]);
    end
  end

  assign result_ch.valid = valid;

endmodule

// ===== rtl/stereo_fast_convolution_fir.sv =====
// Top level of the stereo fast-convolution FIR: sequencer, shared coefficient fetch,
// two filter lanes and the merging stage. Depends on sfcf_pkg, both interfaces and submodules.

// One stereo pair enters per transaction and one filtered pair leaves for it, in order.
// Both channels run through the same real TAP_COUNT-tap low-pass filter (linear
// convolution, history zero after reset) in two lanes that work side by side; the
// merging stage packs the two results into the output register. Each lane does one
// multiply-accumulate per tap per cycle. A pair goes through one accept step, TAP_COUNT
// operand fetches, the drain of the multiplier and accumulator registers, and one
// finalize step that moves the result into the output register; a new pair is accepted
// only once that finalize step is done. A waiting result does not block the next pair;
// the finalize step waits only if the previous result is still held. Coefficients are
// Q1.15 scaled to COEFF_BITS, products sum in a 40-bit wrapping accumulator, and the
// sum is truncated toward zero and saturated.
module stereo_fast_convolution_fir #(
  parameter int TAP_COUNT   = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  sfcf_in_if.sink    sample_ch,
  sfcf_out_if.source result_ch
);

  localparam int FB    = sfcf_pkg::FIELD_BITS;
  localparam int MW    = (SAMPLE_BITS > FB) ? SAMPLE_BITS : FB;
  localparam int CNT_W = $clog2(TAP_COUNT + 2);

  sfcf_pkg::state_t    state;
  sfcf_pkg::state_t    state_next;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  sfcf_pkg::lane_ctl_t ctl;
  logic signed [COEFF_BITS-1:0]  coef;
  logic signed [SAMPLE_BITS-1:0] sample_a;
  logic signed [SAMPLE_BITS-1:0] sample_b;
  logic signed [SAMPLE_BITS-1:0] res_a;
  logic signed [SAMPLE_BITS-1:0] res_b;
  logic [MW-1:0]       in_wide_a;
  logic [MW-1:0]       in_wide_b;
  logic                can_load;
  logic                accept;

  // Keep the low SAMPLE_BITS of each field; wider samples see the field zero-extended.
  assign in_wide_a = MW'($unsigned(sample_ch.chan_a_in));
  assign in_wide_b = MW'($unsigned(sample_ch.chan_b_in));
  assign sample_a  = $signed(in_wide_a[SAMPLE_BITS-1:0]);
  assign sample_b  = $signed(in_wide_b[SAMPLE_BITS-1:0]);

  assign sample_ch.ready = (state == sfcf_pkg::ST_IDLE);
  assign accept          = sample_ch.valid && sample_ch.ready;

  // State register and tap counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfcf_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Sequencer: fetch taps 0..TAP_COUNT-1, drain the multiplier and accumulator,
  // then hand the result to the merging stage and commit the sample to history.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    unique case (state)
      sfcf_pkg::ST_IDLE: begin
        ctl.load = accept;
        if (accept) begin
          state_next = sfcf_pkg::ST_MAC;
          cnt_next   = '0;
        end
      end
      sfcf_pkg::ST_MAC: begin
        ctl.issue = (cnt < CNT_W'(TAP_COUNT));
        ctl.first = (cnt == '0);
        ctl.mul   = (cnt >= CNT_W'(1)) && (cnt <= CNT_W'(TAP_COUNT));
        ctl.acc   = (cnt >= CNT_W'(2));
        if (cnt == CNT_W'(TAP_COUNT + 1)) begin
          state_next = sfcf_pkg::ST_FIN;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      sfcf_pkg::ST_FIN: begin
        // Hold until the output register is free or being emptied.
        ctl.commit = can_load;
        if (can_load) begin
          state_next = sfcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sfcf_pkg::ST_IDLE;
      end
    endcase
  end

  // Shared coefficient fetch, registered beside the lane operands.
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      coef <= COEFF_BITS'(sfcf_pkg::coef_value(int'(cnt), COEFF_BITS));
    end
  end

  sfcf_lane #(
    .TAP_COUNT  (TAP_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_lane_a (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .sample(sample_a),
    .coef  (coef),
    .result(res_a)
  );

  sfcf_lane #(
    .TAP_COUNT  (TAP_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_lane_b (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .sample(sample_b),
    .coef  (coef),
    .result(res_b)
  );

  sfcf_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (ctl.commit),
    .res_a    (res_a),
    .res_b    (res_b),
    .can_load (can_load),
    .result_ch(result_ch)
  );

  // An accepted pair starts the tap sweep at tap zero.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == sfcf_pkg::ST_MAC) && (cnt == '0))
    else $error("tap sweep did not start after accepting a pair");

  // The tap counter never runs past the drain cycles.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sfcf_pkg::ST_MAC) |-> (cnt <= CNT_W'(TAP_COUNT + 1)))
    else $error("tap counter out of range");

  // A new result appears only right after a finalize step.
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_ch.valid) |-> $past(state == sfcf_pkg::ST_FIN))
    else $error("result presented without a finalize step");

  // History is committed only while the output register can take the result.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (!result_ch.valid || result_ch.ready))
    else $error("result committed over an untaken result");

endmodule
